// ----- design/rscpt_pkg.sv -----
// ----------------------------------------------------------------------------
// rscpt_pkg
// Shared types and constants for the reference-counted shared page table:
// table geometry, operation and status codes, and the stored entry layout.
// ----------------------------------------------------------------------------
package rscpt_pkg;

    // Table geometry and field widths.
    localparam int ENTRIES   = 64;
    localparam int IDXW      = $clog2(ENTRIES);
    localparam int WORDW     = 32;
    localparam int FRAMEW    = 44;
    localparam int CNTW      = 16;
    localparam int OPW       = 2;
    localparam int STATW     = 3;
    localparam int IN_DATAW  = 144;
    localparam int OUT_DATAW = 48;

    localparam logic [CNTW-1:0] COUNT_MAX = '1;

    typedef logic [IDXW-1:0] t_idx;

    // Request operations.
    typedef enum logic [OPW-1:0] {
        OP_GET     = 2'd0,
        OP_MARK    = 2'd1,
        OP_QUERY   = 2'd2,
        OP_RELEASE = 2'd3
    } t_op;

    // Result status codes.
    typedef enum logic [STATW-1:0] {
        ST_HIT      = 3'd0,
        ST_NEW      = 3'd1,
        ST_FULL     = 3'd2,
        ST_NOFRAME  = 3'd3,
        ST_NOTFOUND = 3'd4,
        ST_DONE     = 3'd5,
        ST_HELD     = 3'd6,
        ST_FREED    = 3'd7
    } t_status;

    // Sequencer states.
    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_SCAN = 2'd1,
        S_EXEC = 2'd2
    } t_state;

    // Page key of a request.
    typedef struct packed {
        logic [WORDW-1:0] dev;
        logic [WORDW-1:0] inode;
        logic [WORDW-1:0] offset;
    } t_key;

    // One stored table entry; the valid bit lives in flip-flops outside.
    typedef struct packed {
        t_key              key;
        logic [FRAMEW-1:0] frame;
        logic [CNTW-1:0]   count;
        logic              ready;
    } t_entry;

    // Outcome of comparing one entry against the pending request.
    typedef struct packed {
        logic key_hit;
        logic frame_hit;
        logic is_free;
    } t_cmp_res;

endpackage

// ----- design/rscpt_mem.sv -----
// ----------------------------------------------------------------------------
// rscpt_mem
// Entry storage: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module rscpt_mem
    import rscpt_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_we,
    input  t_idx   i_waddr,
    input  t_entry i_wdata,
    input  logic   i_re,
    input  t_idx   i_raddr,
    output t_entry o_rdata
);

    t_entry r_mem [ENTRIES];
    t_entry r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, registered.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- design/rscpt_cmp.sv -----
// ----------------------------------------------------------------------------
// rscpt_cmp
// Shared compare unit: checks one entry against the pending key and frame.
// ----------------------------------------------------------------------------
module rscpt_cmp
    import rscpt_pkg::*;
(
    input  t_entry            i_entry,
    input  logic              i_valid,
    input  t_key              i_key,
    input  logic [FRAMEW-1:0] i_frame,
    output t_cmp_res          o_res
);

    // A frame of zero never matches any entry.
    assign o_res.key_hit   = i_valid && (i_entry.key == i_key);
    assign o_res.frame_hit = i_valid && (i_frame != '0) && (i_entry.frame == i_frame);
    assign o_res.is_free   = !i_valid;

endmodule

// ----- design/refcounted_shared_page_table_top.sv -----
// ----------------------------------------------------------------------------
// refcounted_shared_page_table_top
// Table of shared pages keyed by device, inode and offset, with use counts.
//
// Usage:
//   A request word enters on the s_axis channel: tuser carries the operation
//   (get, mark initialized, query initialized, release) and tdata the key and
//   the frame. One result word leaves on the m_axis channel per request.
//   Each request scans the table one entry per cycle through a single compare
//   unit fed by the entry memory read port. A scan stops at the first match;
//   a miss walks all 64 entries. A new request is taken only once the last
//   one has loaded its result; the input is not ready while a request scans.
//   The result sits in an output register; a stalled receiver holds it there
//   and the next request may scan meanwhile, waiting only to retire.
//   Reset clears all valid bits at once, so the table starts empty and no
//   clearing pass is needed.
// ----------------------------------------------------------------------------
module refcounted_shared_page_table_top
    import rscpt_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Request channel.
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // tdata: key_dev[31:0], key_inode[63:32], key_offset[95:64],
    //        page_frame[139:96], zero pad[143:140]
    input  logic [IN_DATAW-1:0]  s_axis_tdata,
    // tuser: op[1:0]
    input  logic [OPW-1:0]       s_axis_tuser,
    // Result channel.
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // tdata: status[2:0], result_frame[46:3], is_initialized[47]
    output logic [OUT_DATAW-1:0] m_axis_tdata
);

    localparam logic [IDXW:0] IDX_END  = (IDXW+1)'(ENTRIES);
    localparam t_idx          IDX_LAST = IDXW'(ENTRIES - 1);

    t_state            r_state, n_state;
    logic [IDXW:0]     r_idx, n_idx;
    logic              r_stage_v, n_stage_v;
    t_idx              r_cmp_idx;
    logic [ENTRIES-1:0] r_valid, n_valid;
    logic              r_hit_found, n_hit_found;
    t_idx              r_hit_idx, n_hit_idx;
    t_entry            r_hit_entry, n_hit_entry;
    logic              r_free_found, n_free_found;
    t_idx              r_free_idx, n_free_idx;

    // Latched request.
    t_op               r_op;
    t_key              r_key;
    logic [FRAMEW-1:0] r_frame;

    // Output register.
    logic              r_out_valid;
    t_status           r_out_status;
    logic [FRAMEW-1:0] r_out_frame;
    logic              r_out_init;

    logic              w_load;
    t_status           w_status;
    logic [FRAMEW-1:0] w_frame;
    logic              w_init;
    logic              w_we;
    t_idx              w_waddr;
    t_entry            w_wdata;
    logic              w_re;
    t_entry            w_rdata;
    t_cmp_res          w_cmp;
    logic              w_accept;

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    // Entry storage and compare unit.
    rscpt_mem u_mem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (r_idx[IDXW-1:0]),
        .o_rdata (w_rdata)
    );

    rscpt_cmp u_cmp (
        .i_entry (w_rdata),
        .i_valid (r_valid[r_cmp_idx]),
        .i_key   (r_key),
        .i_frame (r_frame),
        .o_res   (w_cmp)
    );

    // Sequencer: next state, scan bookkeeping, table update and result.
    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_stage_v    = 1'b0;
        n_valid      = r_valid;
        n_hit_found  = r_hit_found;
        n_hit_idx    = r_hit_idx;
        n_hit_entry  = r_hit_entry;
        n_free_found = r_free_found;
        n_free_idx   = r_free_idx;
        w_re         = 1'b0;
        w_we         = 1'b0;
        w_waddr      = r_hit_idx;
        w_wdata      = r_hit_entry;
        w_load       = 1'b0;
        w_status     = ST_NOTFOUND;
        w_frame      = '0;
        w_init       = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_state      = S_SCAN;
                    n_idx        = '0;
                    n_hit_found  = 1'b0;
                    n_free_found = 1'b0;
                end
            end
            S_SCAN: begin
                // Issue the next read while comparing the previous entry.
                if (r_idx < IDX_END) begin
                    w_re      = 1'b1;
                    n_idx     = r_idx + 1'b1;
                    n_stage_v = 1'b1;
                end
                if (r_stage_v) begin
                    if ((r_op == OP_GET && w_cmp.key_hit) ||
                        (r_op != OP_GET && w_cmp.frame_hit)) begin
                        n_hit_found = 1'b1;
                        n_hit_idx   = r_cmp_idx;
                        n_hit_entry = w_rdata;
                        n_stage_v   = 1'b0;
                        n_state     = S_EXEC;
                    end else begin
                        if (w_cmp.is_free && !r_free_found) begin
                            n_free_found = 1'b1;
                            n_free_idx   = r_cmp_idx;
                        end
                        if (r_cmp_idx == IDX_LAST) begin
                            n_stage_v = 1'b0;
                            n_state   = S_EXEC;
                        end
                    end
                end
            end
            S_EXEC: begin
                if (!r_out_valid || m_axis_tready) begin
                    w_load  = 1'b1;
                    n_state = S_IDLE;
                    if (r_op == OP_GET) begin
                        if (r_hit_found) begin
                            // Hit: bump the count, saturating.
                            w_we     = 1'b1;
                            if (r_hit_entry.count != COUNT_MAX) begin
                                w_wdata.count = r_hit_entry.count + 1'b1;
                            end
                            w_status = ST_HIT;
                            w_frame  = r_hit_entry.frame;
                        end else if (!r_free_found) begin
                            w_status = ST_FULL;
                        end else if (r_frame == '0) begin
                            w_status = ST_NOFRAME;
                        end else begin
                            // Claim the lowest free entry.
                            w_we                = 1'b1;
                            w_waddr             = r_free_idx;
                            w_wdata.key         = r_key;
                            w_wdata.frame       = r_frame;
                            w_wdata.count       = CNTW'(1);
                            w_wdata.ready       = 1'b0;
                            n_valid[r_free_idx] = 1'b1;
                            w_status            = ST_NEW;
                            w_frame             = r_frame;
                        end
                    end else if (r_hit_found) begin
                        case (r_op)
                            OP_MARK: begin
                                w_we          = 1'b1;
                                w_wdata.ready = 1'b1;
                                w_status      = ST_DONE;
                            end
                            OP_QUERY: begin
                                w_status = ST_DONE;
                                w_init   = r_hit_entry.ready;
                            end
                            default: begin
                                // Release: free the entry once no user is left.
                                if (r_hit_entry.count <= CNTW'(1)) begin
                                    n_valid[r_hit_idx] = 1'b0;
                                    w_status           = ST_FREED;
                                    w_frame            = r_hit_entry.frame;
                                end else begin
                                    w_we          = 1'b1;
                                    w_wdata.count = r_hit_entry.count - 1'b1;
                                    w_status      = ST_HELD;
                                end
                            end
                        endcase
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_idx        <= '0;
            r_stage_v    <= 1'b0;
            r_valid      <= '0;
            r_hit_found  <= 1'b0;
            r_free_found <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_idx        <= n_idx;
            r_stage_v    <= n_stage_v;
            r_valid      <= n_valid;
            r_hit_found  <= n_hit_found;
            r_free_found <= n_free_found;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_hit_idx   <= n_hit_idx;
        r_hit_entry <= n_hit_entry;
        r_free_idx  <= n_free_idx;
        if (w_re) begin
            r_cmp_idx <= r_idx[IDXW-1:0];
        end
        if (w_accept) begin
            r_op         <= t_op'(s_axis_tuser);
            r_key.dev    <= s_axis_tdata[31:0];
            r_key.inode  <= s_axis_tdata[63:32];
            r_key.offset <= s_axis_tdata[95:64];
            r_frame      <= s_axis_tdata[139:96];
        end
        if (w_load) begin
            r_out_status <= w_status;
            r_out_frame  <= w_frame;
            r_out_init   <= w_init;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_init, r_out_frame, r_out_status};

    // Checks on the sequencer and the valid bits.
    a_accept_scans: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_state == S_SCAN)
        else $error("accepted request did not start a scan");

    a_pipe_align: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && r_stage_v) |-> r_idx == {1'b0, r_cmp_idx} + 1'b1)
        else $error("compare stage out of step with read address");

    a_new_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && w_status == ST_NEW) |=>
            $countones(r_valid) == $past($countones(r_valid)) + 1)
        else $error("new entry did not set one valid bit");

    a_freed_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && w_status == ST_FREED) |=>
            $countones(r_valid) == $past($countones(r_valid)) - 1)
        else $error("freed entry did not clear one valid bit");

    a_no_load_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !m_axis_tready) |-> !w_load)
        else $error("result overwritten while the receiver stalls");

endmodule

// ----- verif/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the reference-counted shared page table. A driver
// feeds request words from a queue and a behavioral table model predicts the
// status, frame and initialized flag of every result word. A monitor compares
// each result with the oldest prediction. Stimulus runs a directed pass over
// the corner cases, a table-fill pass, and random get/mark/query/release
// traffic over a small key pool, with one long receiver stall.
// ----------------------------------------------------------------------------
module testbench;
    import rscpt_pkg::*;

    localparam int CYCLE_LIMIT = 5_000_000;
    localparam int KEY_POOL    = 96;
    localparam int REPORT_MAX  = 50;
    localparam int PAD_W       = IN_DATAW - FRAMEW - 3 * WORDW;
    localparam logic [FRAMEW-1:0] FRAME_TOP = '1;

    // One request and one result word, unpacked.
    typedef struct {
        t_op               op;
        logic [WORDW-1:0]  dev;
        logic [WORDW-1:0]  inode;
        logic [WORDW-1:0]  offset;
        logic [FRAMEW-1:0] frame;
    } t_page_req;

    typedef struct {
        t_status           status;
        logic [FRAMEW-1:0] frame;
        logic              init;
    } t_page_rsp;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    // tdata: key_dev[31:0], key_inode[63:32], key_offset[95:64],
    //        page_frame[139:96], zero pad[143:140]
    logic [IN_DATAW-1:0]  s_axis_tdata = '0;
    // tuser: op[1:0]
    logic [OPW-1:0]       s_axis_tuser = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    // tdata: status[2:0], result_frame[46:3], is_initialized[47]
    logic [OUT_DATAW-1:0] m_axis_tdata;

    refcounted_shared_page_table_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Model of the page table.
    logic              tbl_valid  [ENTRIES];
    logic [WORDW-1:0]  tbl_dev    [ENTRIES];
    logic [WORDW-1:0]  tbl_inode  [ENTRIES];
    logic [WORDW-1:0]  tbl_offset [ENTRIES];
    logic [FRAMEW-1:0] tbl_frame  [ENTRIES];
    logic [CNTW-1:0]   tbl_count  [ENTRIES];
    logic              tbl_ready  [ENTRIES];

    t_page_req pending_reqs[$];
    t_page_rsp expected_rsps[$];
    t_page_req cur_req;

    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned error_cnt = 0;
    int unsigned cycle_cnt = 0;
    int unsigned hold_cnt = 0;
    logic        hold_armed = 1'b0;
    logic        hold_done = 1'b0;

    logic [WORDW-1:0]  pool_dev    [KEY_POOL];
    logic [WORDW-1:0]  pool_inode  [KEY_POOL];
    logic [WORDW-1:0]  pool_offset [KEY_POOL];
    logic [FRAMEW-1:0] pool_frame  [KEY_POOL];

    // Applies one request to the table model and returns its result.
    function automatic t_page_rsp apply_page_request(t_page_req rq);
        t_page_rsp rs;
        int        slot;
        slot = -1;
        rs.status = ST_NOTFOUND;
        rs.frame  = '0;
        rs.init   = 1'b0;
        if (rq.op == OP_GET) begin
            for (int i = 0; i < ENTRIES && slot < 0; i++)
                if (tbl_valid[i] && tbl_dev[i] == rq.dev && tbl_inode[i] == rq.inode &&
                    tbl_offset[i] == rq.offset)
                    slot = i;
            if (slot >= 0) begin
                if (tbl_count[slot] != COUNT_MAX)
                    tbl_count[slot] = tbl_count[slot] + 1'b1;
                rs.status = ST_HIT;
                rs.frame  = tbl_frame[slot];
            end else begin
                for (int i = 0; i < ENTRIES && slot < 0; i++)
                    if (!tbl_valid[i])
                        slot = i;
                if (slot < 0) begin
                    rs.status = ST_FULL;
                end else if (rq.frame == '0) begin
                    rs.status = ST_NOFRAME;
                end else begin
                    tbl_valid[slot]  = 1'b1;
                    tbl_dev[slot]    = rq.dev;
                    tbl_inode[slot]  = rq.inode;
                    tbl_offset[slot] = rq.offset;
                    tbl_frame[slot]  = rq.frame;
                    tbl_count[slot]  = CNTW'(1);
                    tbl_ready[slot]  = 1'b0;
                    rs.status = ST_NEW;
                    rs.frame  = rq.frame;
                end
            end
        end else begin
            // Frame zero never matches, not even a free entry.
            if (rq.frame != '0)
                for (int i = 0; i < ENTRIES && slot < 0; i++)
                    if (tbl_valid[i] && tbl_frame[i] == rq.frame)
                        slot = i;
            if (slot < 0) begin
                rs.status = ST_NOTFOUND;
            end else if (rq.op == OP_MARK) begin
                tbl_ready[slot] = 1'b1;
                rs.status = ST_DONE;
            end else if (rq.op == OP_QUERY) begin
                rs.init   = tbl_ready[slot];
                rs.status = ST_DONE;
            end else begin
                if (tbl_count[slot] != '0)
                    tbl_count[slot] = tbl_count[slot] - 1'b1;
                if (tbl_count[slot] == '0) begin
                    rs.frame  = tbl_frame[slot];
                    rs.status = ST_FREED;
                    tbl_valid[slot] = 1'b0;
                    tbl_frame[slot] = '0;
                    tbl_ready[slot] = 1'b0;
                end else begin
                    rs.status = ST_HELD;
                end
            end
        end
        return rs;
    endfunction

    // Clock.
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Cycle limit.
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Long receiver hold-off, fired once when armed.
    always @(posedge i_clk) begin
        if (hold_armed && !hold_done) begin
            hold_cnt  <= 600;
            hold_done <= 1'b1;
        end else if (hold_cnt != 0) begin
            hold_cnt <= hold_cnt - 1;
        end
    end

    // Request driver; an accepted word is predicted at the edge that takes it.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                expected_rsps.push_back(apply_page_request(cur_req));
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    cur_req = pending_reqs.pop_front();
                    s_axis_tdata  <= {{PAD_W{1'b0}}, cur_req.frame, cur_req.offset,
                                      cur_req.inode, cur_req.dev};
                    s_axis_tuser  <= cur_req.op;
                    s_axis_tvalid <= 1'b1;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result monitor and receiver back-pressure.
    always @(posedge i_clk) begin
        t_page_rsp exp_rsp;
        m_axis_tready <= (hold_cnt == 0) && ($urandom_range(99) >= recv_idle_pct);
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_rsps.size() == 0) begin
                error_cnt <= error_cnt + 1;
                if (error_cnt < REPORT_MAX)
                    $display("%0t: unexpected result word, expected none, actual %h",
                             $time, m_axis_tdata);
            end else begin
                exp_rsp = expected_rsps.pop_front();
                if (m_axis_tdata[STATW-1:0] != exp_rsp.status ||
                    m_axis_tdata[STATW+FRAMEW-1:STATW] != exp_rsp.frame ||
                    m_axis_tdata[STATW+FRAMEW] != exp_rsp.init) begin
                    error_cnt <= error_cnt + 1;
                    if (error_cnt < REPORT_MAX)
                        $display("%0t: expected status %s frame %h init %b, actual %0d %h %b",
                                 $time, exp_rsp.status.name(), exp_rsp.frame, exp_rsp.init,
                                 m_axis_tdata[STATW-1:0], m_axis_tdata[STATW+FRAMEW-1:STATW],
                                 m_axis_tdata[STATW+FRAMEW]);
                end
            end
        end
    end

    task automatic push_req(t_op op, logic [WORDW-1:0] dev, logic [WORDW-1:0] inode,
                            logic [WORDW-1:0] offset, logic [FRAMEW-1:0] frame);
        t_page_req rq;
        rq.op     = op;
        rq.dev    = dev;
        rq.inode  = inode;
        rq.offset = offset;
        rq.frame  = frame;
        pending_reqs.push_back(rq);
    endtask

    function automatic logic [FRAMEW-1:0] rand_frame();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        return raw[FRAMEW-1:0];
    endfunction

    // Waits until every word is sent and every result has come back.
    task automatic wait_drained();
        do
            @(negedge i_clk);
        while (pending_reqs.size() != 0 || s_axis_tvalid || expected_rsps.size() != 0);
    endtask

    // Random traffic: mostly get/use/release sequences on pool keys, some noise.
    task automatic push_random_traffic(int unsigned n_items);
        int unsigned      pushed;
        int unsigned      k;
        int unsigned      sel;
        logic [FRAMEW-1:0] fr;
        pushed = 0;
        while (pushed < n_items) begin
            k = $urandom_range(KEY_POOL - 1);
            if ($urandom_range(99) < 65) begin
                push_req(OP_GET, pool_dev[k], pool_inode[k], pool_offset[k], pool_frame[k]);
                pushed++;
                if ($urandom_range(1)) begin
                    push_req(t_op'($urandom_range(OP_MARK, OP_QUERY)), $urandom, $urandom,
                             $urandom, pool_frame[k]);
                    pushed++;
                end
                if ($urandom_range(99) < 55) begin
                    push_req(OP_RELEASE, $urandom, $urandom, $urandom, pool_frame[k]);
                    pushed++;
                end
            end else begin
                sel = $urandom_range(99);
                if (sel < 10)
                    fr = '0;
                else if (sel < 30)
                    fr = rand_frame();
                else
                    fr = pool_frame[$urandom_range(KEY_POOL - 1)];
                if ($urandom_range(1))
                    push_req(t_op'($urandom_range(3)), pool_dev[k], pool_inode[k],
                             pool_offset[k], fr);
                else
                    push_req(t_op'($urandom_range(3)), $urandom, $urandom, $urandom, fr);
                pushed++;
            end
        end
    endtask

    // Stimulus sequence.
    initial begin
        logic [FRAMEW-1:0] fill_frame [66];
        logic [FRAMEW-1:0] frame_c;
        frame_c = {1'b1, {(FRAMEW-1){1'b0}}};
        for (int i = 0; i < ENTRIES; i++) begin
            tbl_valid[i] = 1'b0;
            tbl_frame[i] = '0;
            tbl_count[i] = '0;
            tbl_ready[i] = 1'b0;
        end
        for (int k = 0; k < KEY_POOL; k++) begin
            pool_dev[k]    = $urandom;
            pool_inode[k]  = $urandom;
            pool_offset[k] = $urandom;
            pool_frame[k]  = rand_frame();
            if (pool_frame[k] == '0 || pool_frame[k] == FRAME_TOP)
                pool_frame[k] = FRAMEW'(k + 2);
            // Every sixteenth key shares its frame with the key before it.
            if (k % 16 == 15)
                pool_frame[k] = pool_frame[k-1];
        end

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Phase one: sender idles a little, receiver a lot.
        send_idle_pct = 8;
        recv_idle_pct = 79;
        // The all-zero key with the top frame lands in entry 0 and stays live.
        push_req(OP_GET, '0, '0, '0, FRAME_TOP);
        push_req(OP_GET, '1, '1, '1, '0);
        push_req(OP_GET, '1, '1, '1, 44'h1);
        push_req(OP_GET, '0, '0, '0, 44'h5);
        push_req(OP_QUERY, '0, '0, '0, FRAME_TOP);
        push_req(OP_MARK, '1, '1, '1, FRAME_TOP);
        push_req(OP_QUERY, '0, '0, '0, FRAME_TOP);
        push_req(OP_MARK, '0, '0, '0, '0);
        push_req(OP_QUERY, '0, '0, '0, '0);
        push_req(OP_RELEASE, '0, '0, '0, '0);
        push_req(OP_RELEASE, '0, '0, '0, 44'h5A5);
        push_req(OP_MARK, '0, '0, '0, 44'h5A5);
        push_req(OP_QUERY, '0, '0, '0, 44'h5A5);
        // A second key with the same frame; frame lookups pick the lower entry.
        push_req(OP_GET, 32'h5555_5555, 32'hAAAA_AAAA, 32'h1234_5678, 44'h1);
        push_req(OP_MARK, '0, '0, '0, 44'h1);
        push_req(OP_GET, '1, '1, '1, 44'h7);
        push_req(OP_RELEASE, '0, '0, '0, 44'h1);
        push_req(OP_RELEASE, '0, '0, '0, 44'h1);
        push_req(OP_QUERY, '0, '0, '0, 44'h1);
        push_req(OP_RELEASE, '0, '0, '0, 44'h1);
        push_req(OP_RELEASE, '0, '0, '0, 44'h1);
        push_req(OP_GET, 32'h5555_5555, 32'hAAAA_AAAA, 32'h1234_5678, frame_c);
        push_req(OP_RELEASE, '0, '0, '0, FRAME_TOP);
        push_req(OP_RELEASE, '0, '0, '0, frame_c);
        push_random_traffic(550);
        wait_drained();

        // Phase two: the other way round; fill the table past full, then release the fill keys.
        send_idle_pct = 79;
        recv_idle_pct = 8;
        for (int i = 0; i < 66; i++) begin
            fill_frame[i] = rand_frame() | 44'h1;
            push_req(OP_GET, $urandom, $urandom, $urandom, fill_frame[i]);
        end
        push_req(OP_GET, $urandom, $urandom, $urandom, '0);
        push_req(OP_GET, $urandom, $urandom, $urandom, rand_frame() | 44'h1);
        push_req(OP_QUERY, '0, '0, '0, FRAME_TOP);
        for (int i = 0; i < 66; i++)
            push_req(OP_RELEASE, $urandom, $urandom, $urandom, fill_frame[i]);
        push_random_traffic(480);
        wait_drained();

        // Phase three: no idling, one long receiver stall while requests pile up.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_armed <= 1'b1;
        push_random_traffic(460);
        push_req(OP_RELEASE, '0, '0, '0, FRAME_TOP);
        push_req(OP_QUERY, '0, '0, '0, FRAME_TOP);
        wait_drained();

        repeat (80) @(posedge i_clk);
        if (error_cnt == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
